### hdl/min_tracking_stack_assert.svh
// Assertion macros for the min tracking stack.
// Used by min_tracking_stack.sv; expects clock and reset in scope.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Check that cons holds in the cycle where ante holds.
`define MTS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("min tracking stack check failed");

// Check that cons holds in the cycle after ante holds.
`define MTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("min tracking stack check failed");

`endif

### hdl/mts_pkg.sv
// Shared types and constants for the min tracking stack.
// No dependencies; used by mts_cell.sv and min_tracking_stack.sv.
`default_nettype none

package mts_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W        = 32;
   localparam int OP_W          = 2;
   localparam int ERR_W         = 2;
   localparam int ENTRY_COUNT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   // One stack entry: the value and the minimum of it and all below.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] run_min;
   } entry_type;

   // Shift control broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

`default_nettype wire

### hdl/mts_cell.sv
// One stack cell: holds an entry, shifts down on push, up on pop.
// Depends on mts_pkg.
`default_nettype none

module mts_cell (
   input  wire                   clock,
   input  mts_pkg::shift_type    shift,
   input  mts_pkg::entry_type    from_above,
   input  mts_pkg::entry_type    from_below,
   output mts_pkg::entry_type    entry
);

   mts_pkg::entry_type entry_ff;
   mts_pkg::entry_type entry_in;

   always_comb begin
      priority if (shift.push) begin
         entry_in = from_above;
      end else if (shift.pop) begin
         entry_in = from_below;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

### hdl/min_tracking_stack.sv
// Top level of the min tracking stack: a chain of mts_cell entries and control.
// Depends on mts_pkg, mts_cell and min_tracking_stack_assert.svh.
`default_nettype none
`include "min_tracking_stack_assert.svh"

// Usage
//   req channel: one word per request, op in req_tdata[1:0] (0 push, 1 pop,
//   2 or 3 peek) and the signed push value in req_tdata[33:2].
//   rsp channel: exactly one word per request, in request order, giving the
//   top value, the running minimum, the entry count and an error code.
//   Timing: the response word is registered and appears in the cycle after
//   the request word is taken. Throughput: one request per cycle while the
//   receiver takes each response; the stack is a row of cells that all shift by
//   one place in the same cycle; the top two cells give the next result at once.
//   The response sits in an output register; a new request is taken while
//   that register is empty or its word is being taken, so a stalled
//   receiver holds the response and holds off further requests.
//   Push on a full stack is dropped (error 1); pop or peek on an empty stack
//   changes nothing (error 2) and reports zero top and minimum.
//   Reset (synchronous, active high) empties the stack and drops any pending
//   response; cell contents are not cleared, only the count.
module min_tracking_stack (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [39:0]  req_tdata,   // [1:0] op, [33:2] push_value, [39:34] zero
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [79:0]  rsp_tdata    // [31:0] top_value, [63:32] min_value,
                                     // [70:64] entry_count, [72:71] error_code,
                                     // [79:73] zero
);

   localparam int D = mts_pkg::STACK_DEPTH;
   localparam int CW = mts_pkg::COUNT_W;
   localparam int DW = mts_pkg::DATA_W;

   // Request decode
   logic [mts_pkg::OP_W-1:0]  req_op;
   logic signed [DW-1:0]      req_value;
   logic                      accept;
   logic                      full;
   logic                      empty;
   logic                      do_push;
   logic                      do_pop;
   mts_pkg::err_type          err;

   // Stack state
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   mts_pkg::entry_type        cells [D];
   mts_pkg::entry_type        new_entry;
   mts_pkg::shift_type        shift;

   // Response register
   logic                      rsp_tvalid_ff;
   logic                      rsp_tvalid_in;
   logic [79:0]               rsp_data_ff;
   logic [79:0]               rsp_data_in;
   logic signed [DW-1:0]      res_top;
   logic signed [DW-1:0]      res_min;

   assign req_op    = req_tdata[1:0];
   assign req_value = req_tdata[33:2];

   // Take a word whenever the response slot is free or draining.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = (count_ff == CW'(D));
   assign empty = (count_ff == '0);

   assign do_push = accept && (req_op == mts_pkg::OP_PUSH) && !full;
   assign do_pop  = accept && (req_op == mts_pkg::OP_POP) && !empty;

   always_comb begin
      priority if ((req_op == mts_pkg::OP_PUSH) && full) begin
         err = mts_pkg::ERR_FULL;
      end else if ((req_op != mts_pkg::OP_PUSH) && empty) begin
         err = mts_pkg::ERR_EMPTY;
      end else begin
         err = mts_pkg::ERR_NONE;
      end
   end

   // New top entry: keep the smaller of the pushed value and the minimum below.
   always_comb begin
      new_entry.value   = req_value;
      new_entry.run_min = req_value;
      if (!empty && (cells[0].run_min < req_value)) begin
         new_entry.run_min = cells[0].run_min;
      end
   end

   assign shift.push = do_push;
   assign shift.pop  = do_pop;

   // Row of cells: cell 0 is the top; push moves each entry one place down.
   for (genvar i = 0; i < D; i++) begin : g_cell
      mts_pkg::entry_type above;
      mts_pkg::entry_type below;
      if (i == 0) begin : g_top
         assign above = new_entry;
      end else begin : g_mid
         assign above = cells[i-1];
      end
      if (i == D - 1) begin : g_bottom
         assign below = cells[i];
      end else begin : g_upper
         assign below = cells[i+1];
      end
      mts_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .entry      (cells[i])
      );
   end

   always_comb begin
      priority if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Result from the top two cells as they will be after this request.
   always_comb begin
      priority if (count_in == '0) begin
         res_top = '0;
         res_min = '0;
      end else if (do_push) begin
         res_top = new_entry.value;
         res_min = new_entry.run_min;
      end else if (do_pop) begin
         res_top = cells[1].value;
         res_min = cells[1].run_min;
      end else begin
         res_top = cells[0].value;
         res_min = cells[0].run_min;
      end
   end

   always_comb begin
      rsp_data_in = {7'd0, err, mts_pkg::ENTRY_COUNT_W'(count_in), res_min, res_top};
   end

   // Hold the response until taken; load a new one on each accepted word.
   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MTS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(D))
   `MTS_ASSERT_NEXT(a_push_grows, do_push, count_ff == $past(count_ff) + CW'(1))
   `MTS_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_tvalid_ff)
   `MTS_ASSERT_SAME(a_empty_reads_zero, rsp_tvalid_ff && (rsp_data_ff[70:64] == '0),
                    rsp_data_ff[63:0] == '0)

endmodule

`default_nettype wire
